[rtl/etx_rank_parent_select_defines.svh]
// assertion macros shared by the controller and datapath of the etx rank parent select block
// expects signals named clock and reset in the module that uses them
`ifndef ETX_RANK_PARENT_SELECT_DEFINES_SVH
`define ETX_RANK_PARENT_SELECT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ERPS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ERPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/erps_pkg.sv]
// shared constants, codes and controller/datapath interface types
// for the etx rank parent select block; no dependencies
`default_nettype none

package erps_pkg;

   localparam int NODES      = 64;
   localparam int NODE_W     = 6;
   localparam int LINK_DEPTH = NODES * NODES;
   localparam int LINK_AW    = 2 * NODE_W;
   localparam logic [LINK_AW-1:0] LINK_LAST = LINK_AW'(LINK_DEPTH - 1);

   localparam logic [15:0] RANK_INF  = 16'hFFFF;
   localparam logic [15:0] CNT_MAX   = 16'hFFFF;
   localparam logic [6:0]  NO_PARENT = 7'd64;
   localparam logic [6:0]  JOIN_MAX  = 7'd127;
   localparam logic [7:0]  MIN_SAMPLES_RST = 8'd10;

   // etx and rank increase for the two fixed cases
   localparam logic [23:0] ETX_TEN     = 24'd2560;
   localparam logic [23:0] ETX_HUNDRED = 24'd25600;
   localparam logic [9:0]  INC_TEN     = 10'd100;
   localparam logic [9:0]  INC_HUNDRED = 10'd1000;

   // quotient of 2560*sent/recv fits 18 bits when recv*100 >= sent
   localparam int QUO_W     = 18;
   localparam int DIV_STEPS = QUO_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // floor(q/10) = (q * ceil(2^21/10)) >> 21, exact for q below 2^18
   localparam logic [QUO_W-1:0] RECIP_TEN = 18'd209716;
   localparam int RECIP_SHIFT = 21;

   typedef enum logic [1:0] {
      ACT_SENT = 2'd0,
      ACT_RECV = 2'd1,
      ACT_ROOT = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SIG_NONE         = 2'd0,
      SIG_CONSISTENT   = 2'd1,
      SIG_INCONSISTENT = 2'd2
   } trickle_type;

   typedef struct packed {
      logic        joined;
      logic [6:0]  parent;
      logic [15:0] rank;
      logic [23:0] etx;
   } node_word_type;

   localparam node_word_type NODE_RST = '{joined: 1'b0, parent: NO_PARENT,
                                          rank: RANK_INF, etx: 24'd0};

   typedef struct packed {
      logic               clear;
      logic [LINK_AW-1:0] clr_addr;
      logic               capture;
      logic               read;
      logic               load;
      logic               classify;
      logic               div_step;
      logic               scale;
      logic               commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic div_needed;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/erps_ctrl.sv]
// sequencing state machine for the etx rank parent select block
// uses erps_pkg and the assertion macros header
`default_nettype none
`include "etx_rank_parent_select_defines.svh"

module erps_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire erps_pkg::dp_status_type status,
   output erps_pkg::ctl_cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_CLASS,
      ST_DIV,
      ST_SCALE,
      ST_COMMIT
   } state_type;

   state_type                           state_ff, state_in;
   logic [erps_pkg::LINK_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [erps_pkg::DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.clr_addr = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear  = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == erps_pkg::LINK_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.load = 1'b1;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            div_cnt_in   = '0;
            state_in     = status.div_needed ? ST_DIV : ST_COMMIT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == erps_pkg::DIV_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold here while the previous result is still unread
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   `ERPS_ASSERT_NEXT(a_accept_reads, (req_tvalid && req_tready), (state_ff == ST_READ), "accepted beat did not start a read")
   `ERPS_ASSERT_IMPL(a_div_count, (state_ff == ST_DIV), (32'(div_cnt_ff) < erps_pkg::DIV_STEPS), "divide ran past its step count")
   `ERPS_ASSERT_NEXT(a_scale_commit, (state_ff == ST_SCALE), (state_ff == ST_COMMIT), "scale not followed by commit")

endmodule

`default_nettype wire

[rtl/erps_datapath.sv]
// datapath: link counter memories, node state memory, etx divider and
// output register of the etx rank parent select block; uses erps_pkg and the macros header
`default_nettype none
`include "etx_rank_parent_select_defines.svh"

module erps_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [31:0]             req_tdata,
   input  wire logic [1:0]              req_tuser,
   input  wire logic                    csr_wr_en,
   input  wire logic [7:0]              csr_wr_data,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [63:0]                  rsp_tdata,
   input  wire erps_pkg::ctl_cmd_type   cmd,
   output erps_pkg::dp_status_type      status
);

   localparam int NW = erps_pkg::NODE_W;
   localparam int QW = erps_pkg::QUO_W;

   // link counters, cleared by the sweep after reset
   logic [15:0] sent_mem [erps_pkg::LINK_DEPTH];
   logic [15:0] recv_mem [erps_pkg::LINK_DEPTH];

   // node state with a valid bit per entry
   erps_pkg::node_word_type node_mem [erps_pkg::NODES];
   logic [erps_pkg::NODES-1:0] node_vld_ff;

   logic [7:0]  min_samples_ff;

   logic [1:0]  act_ff;
   logic [NW-1:0] snd_ff, rcv_ff;
   logic [15:0] srank_ff;

   logic [15:0] sent_rd_ff, recv_rd_ff;
   erps_pkg::node_word_type node_rd_ff, cur_ff;
   logic        node_rd_vld_ff;

   logic [15:0] s_ff, r_ff;
   logic        rx_ff, rpt_ok_ff;

   logic [23:0] etx_ff;
   logic [9:0]  inc_ff;
   logic [16:0] rem_ff;
   logic [QW-1:0] q_ff;

   logic [6:0]  jc_ff, jc_in;

   logic        out_vld_ff;
   erps_pkg::trickle_type out_sig_ff, sig_in;
   logic        out_fj_ff;
   logic [15:0] out_rank_ff, rank_in;
   logic [6:0]  out_parent_ff, parent_in;
   logic [23:0] out_etx_ff;
   logic [6:0]  out_jt_ff;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == erps_pkg::CNT_MAX) ? v : v + 16'd1;
   endfunction

   // addresses
   logic [NW-1:0]                 naddr;
   logic [erps_pkg::LINK_AW-1:0]  link_addr;
   logic                          in_rng;
   assign naddr     = (act_ff == erps_pkg::ACT_ROOT) ? '0 : rcv_ff;
   assign link_addr = {snd_ff, rcv_ff};
   assign in_rng    = (32'(snd_ff) < erps_pkg::NODES) && (32'(rcv_ff) < erps_pkg::NODES);

   // counter update
   logic        sent_we_in, recv_we_in;
   logic [15:0] s_in, r_in;
   erps_pkg::node_word_type cur_in;
   assign sent_we_in = cmd.load && (act_ff == erps_pkg::ACT_SENT) && in_rng
                       && (snd_ff != rcv_ff);
   assign recv_we_in = cmd.load && (act_ff == erps_pkg::ACT_RECV) && in_rng;
   assign s_in       = (act_ff == erps_pkg::ACT_SENT) ? sat_inc(sent_rd_ff) : sent_rd_ff;
   assign r_in       = sat_inc(recv_rd_ff);
   assign cur_in     = node_rd_vld_ff ? node_rd_ff : erps_pkg::NODE_RST;

   // etx case split
   logic        lt_min, lt_100;
   logic [27:0] n_in;
   assign lt_min = s_ff < {8'd0, min_samples_ff};
   assign lt_100 = ({7'd0, r_ff} * 23'd100) < {7'd0, s_ff};
   assign n_in   = ({12'd0, s_ff} << 11) + ({12'd0, s_ff} << 9);

   assign status.div_needed = rx_ff && !lt_min && !lt_100;
   assign status.out_free   = !out_vld_ff || rsp_tready;

   // restoring divide step
   logic [16:0] trial;
   logic        q_bit;
   assign trial = {rem_ff[15:0], q_ff[QW-1]};
   assign q_bit = trial >= {1'b0, r_ff};

   logic [2*QW-1:0] prod_in;
   assign prod_in = {{QW{1'b0}}, q_ff} * {{QW{1'b0}}, erps_pkg::RECIP_TEN};

   // commit decision
   logic [16:0] cand_sum;
   logic [15:0] cand;
   logic        win, fj, is_root, node_we;
   erps_pkg::node_word_type wd_in;

   always_comb begin
      cand_sum = {1'b0, srank_ff} + {7'd0, inc_ff};
      cand     = cand_sum[16] ? erps_pkg::RANK_INF : cand_sum[15:0];
      win      = rx_ff && (cand < cur_ff.rank);
      fj       = win && !cur_ff.joined;
      is_root  = (act_ff == erps_pkg::ACT_ROOT);
      node_we  = cmd.commit && (is_root || win);
      wd_in    = cur_ff;
      if (is_root) begin
         wd_in.joined = 1'b1;
         wd_in.rank   = 16'd0;
      end else begin
         wd_in.joined = 1'b1;
         wd_in.parent = {1'b0, snd_ff};
         wd_in.rank   = cand;
         wd_in.etx    = etx_ff;
      end
      jc_in = jc_ff;
      if (fj && (jc_ff < erps_pkg::JOIN_MAX)) begin
         jc_in = jc_ff + 7'd1;
      end
      if (!rx_ff) begin
         sig_in = erps_pkg::SIG_NONE;
      end else if (win) begin
         sig_in = erps_pkg::SIG_INCONSISTENT;
      end else begin
         sig_in = erps_pkg::SIG_CONSISTENT;
      end
      if (!rpt_ok_ff) begin
         rank_in   = erps_pkg::RANK_INF;
         parent_in = erps_pkg::NO_PARENT;
      end else if (is_root || win) begin
         rank_in   = wd_in.rank;
         parent_in = wd_in.parent;
      end else begin
         rank_in   = cur_ff.rank;
         parent_in = cur_ff.parent;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         sent_mem[cmd.clr_addr] <= '0;
      end else if (sent_we_in) begin
         sent_mem[link_addr] <= s_in;
      end
      if (cmd.clear) begin
         recv_mem[cmd.clr_addr] <= '0;
      end else if (recv_we_in) begin
         recv_mem[link_addr] <= r_in;
      end
      if (cmd.read) begin
         sent_rd_ff <= sent_mem[link_addr];
         recv_rd_ff <= recv_mem[link_addr];
         node_rd_ff <= node_mem[naddr];
      end
      if (node_we) begin
         node_mem[naddr] <= wd_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_tuser;
         snd_ff   <= req_tdata[5:0];
         rcv_ff   <= req_tdata[11:6];
         srank_ff <= req_tdata[27:12];
      end
      if (cmd.read) begin
         node_rd_vld_ff <= node_vld_ff[naddr];
      end
      if (cmd.load) begin
         s_ff      <= s_in;
         r_ff      <= r_in;
         cur_ff    <= cur_in;
         rx_ff     <= (act_ff == erps_pkg::ACT_RECV) && in_rng && (snd_ff != rcv_ff);
         rpt_ok_ff <= (act_ff == erps_pkg::ACT_ROOT)
                      || ((32'(rcv_ff) < erps_pkg::NODES)
                          && ((act_ff != erps_pkg::ACT_SENT && act_ff != erps_pkg::ACT_RECV)
                              || in_rng));
      end
      if (cmd.classify) begin
         if (!rx_ff) begin
            etx_ff <= '0;
            inc_ff <= '0;
         end else if (lt_min) begin
            etx_ff <= erps_pkg::ETX_TEN;
            inc_ff <= erps_pkg::INC_TEN;
         end else if (lt_100) begin
            etx_ff <= erps_pkg::ETX_HUNDRED;
            inc_ff <= erps_pkg::INC_HUNDRED;
         end
         // top of the dividend is already below the divisor here
         rem_ff <= {7'd0, n_in[27:QW]};
         q_ff   <= n_in[QW-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= q_bit ? (trial - {1'b0, r_ff}) : trial;
         q_ff   <= {q_ff[QW-2:0], q_bit};
      end
      if (cmd.scale) begin
         etx_ff <= {9'd0, prod_in[2*QW-1:erps_pkg::RECIP_SHIFT]};
         inc_ff <= q_ff[QW-1:8];
      end
      if (cmd.commit) begin
         out_sig_ff    <= sig_in;
         out_fj_ff     <= fj;
         out_rank_ff   <= rank_in;
         out_parent_ff <= parent_in;
         out_etx_ff    <= etx_ff;
         out_jt_ff     <= jc_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_samples_ff <= erps_pkg::MIN_SAMPLES_RST;
         node_vld_ff    <= '0;
         jc_ff          <= '0;
         out_vld_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_samples_ff <= csr_wr_data;
         end
         if (node_we) begin
            node_vld_ff[naddr] <= 1'b1;
         end
         if (cmd.commit) begin
            jc_ff      <= jc_in;
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_jt_ff, out_etx_ff, out_parent_ff, out_rank_ff,
                        out_fj_ff, out_sig_ff};

   `ERPS_ASSERT_IMPL(a_commit_free, cmd.commit, (!out_vld_ff || rsp_tready), "result overwritten before it was taken")
   `ERPS_ASSERT_IMPL(a_div_rem, cmd.div_step, (rem_ff < {1'b0, r_ff}), "divider remainder not below divisor")
   `ERPS_ASSERT_IMPL(a_join_bound, 1'b1, (32'(jc_ff) <= erps_pkg::NODES), "joined count above node count")

endmodule

`default_nettype wire

[rtl/etx_rank_parent_select.sv]
// Top level of the etx rank parent select block.
// Built from erps_ctrl and erps_datapath; uses erps_pkg.
//
// Request channel (req_*): one beat per routing event. tuser carries the action
// (dio sent, dio received, start root); tdata carries sender, receiver and the
// rank from the dio. Response channel (rsp_*): exactly one beat per request,
// with trickle signal, first join flag, new rank and parent of the node, link
// etx (8 fraction bits) and the total of joined nodes.
// csr_wr_en/csr_wr_data set min_samples; write only while the block is idle.
// After reset the link counter memories are zeroed by a sweep over all 4096
// entries, one entry per cycle; req_tready stays low until it ends.
// Items are handled one at a time: a request passes through the read,
// evaluate, classify and commit states when etx takes a fixed value, and
// through the restoring divider (18 quotient bits, one per cycle) and a scale
// state before commit when sent/recv is divided; the commit sets the response valid.
// The response sits in an output register: the next request is accepted and
// worked on while it waits, and the block holds before writing its next
// result while rsp_tready stays low.
`default_nettype none

module etx_rank_parent_select (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // sender[5:0], receiver[11:6], sender_rank[27:12]
   input  wire logic [1:0]  req_tuser,  // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // trickle_signal[1:0], first_join[2], new_rank[18:3],
                                        // new_parent[25:19], link_etx[49:26], joined_total[56:50]
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data // min_samples
);

   erps_pkg::ctl_cmd_type   cmd;
   erps_pkg::dp_status_type status;

   erps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   erps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire
